>>> src/bgtb_pkg.sv
// Shared constants, types and helpers for the bitmap glyph text blitter.
`timescale 1ns / 1ps
`default_nettype none
package bgtb_pkg;

  // Sizing
  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_ROWS  = 8;
  localparam int ADDR_WIDTH  = 32;

  localparam int CODE_W      = 8;
  localparam int PIX_W       = 8;
  localparam int COL_W       = 3;
  localparam int ROW_W       = $clog2(GLYPH_ROWS);
  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int STORE_AW    = GLYPH_IDX_W + ROW_W;
  localparam int PEN_W       = 16;
  localparam int PITCH_W     = 14;
  localparam int CLIP_W      = 12;
  localparam int SPAN_W      = CLIP_W + 1;
  localparam int BASE_W      = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;

  // Pen advance per character
  localparam logic [PEN_W-1:0] GLYPH_ADVANCE = PEN_W'(8);

  // Reset value of the line pitch register
  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(640);

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP   = 2'd3;

  localparam logic [CODE_W:0] GLYPH_LIMIT = (CODE_W + 1)'(GLYPH_COUNT);

  // One character render job handed to the raster engine
  typedef struct packed {
    logic [GLYPH_IDX_W-1:0] code;
    logic [PIX_W-1:0]       colour;
    logic [ADDR_WIDTH-1:0]  origin;
  } bgtb_job_t;

  // True when the character code addresses a glyph in the font store
  function automatic logic glyph_ok(input logic [CODE_W-1:0] code);
    glyph_ok = ({1'b0, code} < GLYPH_LIMIT);
  endfunction

endpackage
`default_nettype wire

>>> src/bgtb_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bgtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read data that holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/bgtb_mac.sv
// Bit-serial multiply-add for the line base: base + span * pitch, one span bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bgtb_mac (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [bgtb_pkg::PITCH_W-1:0]    pitch,
  input  wire logic [bgtb_pkg::SPAN_W-1:0]     span,
  input  wire logic [bgtb_pkg::ADDR_WIDTH-1:0] base,
  output logic                                 busy,
  output logic      [bgtb_pkg::ADDR_WIDTH-1:0] acc
);
  import bgtb_pkg::*;

  logic [ADDR_WIDTH-1:0] mcand;
  logic [SPAN_W-1:0]     mplier;

  // Done once no multiplier bits remain
  assign busy = |mplier;

  // Multiplier control
  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (start) begin
      mplier <= span;
    end else if (busy) begin
      mplier <= mplier >> 1;
    end
  end

  // Shift-add datapath; sums wrap at the address width
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= base;
      mcand <= ADDR_WIDTH'(pitch);
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand << 1;
    end
  end

endmodule
`default_nettype wire

>>> src/bgtb_raster.sv
// Glyph raster: shifts rows out one pixel per cycle unless stalled, emitting pixel writes.
`timescale 1ns / 1ps
`default_nettype none
module bgtb_raster (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire bgtb_pkg::bgtb_job_t             job,
  input  wire logic [bgtb_pkg::PITCH_W-1:0]    line_pitch,
  output logic                                 busy,
  output logic                                 rd_en,
  output logic      [bgtb_pkg::STORE_AW-1:0]   rd_addr,
  input  wire logic [bgtb_pkg::PIX_W-1:0]      rd_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [bgtb_pkg::ADDR_WIDTH-1:0] write_addr,
  output logic      [bgtb_pkg::PIX_W-1:0]      write_data,
  output logic                                 last_write
);
  import bgtb_pkg::*;

  typedef enum logic [2:0] {
    R_IDLE  = 3'b001,
    R_BITS  = 3'b010,
    R_FLUSH = 3'b100
  } raster_state_t;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = '1;

  raster_state_t           state;
  raster_state_t           state_next;
  logic [GLYPH_IDX_W-1:0]  code;
  logic [PIX_W-1:0]        colour;
  logic [ADDR_WIDTH-1:0]   row_addr;
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic [PIX_W-1:0]        shreg;
  logic                    pend_valid;
  logic [ADDR_WIDTH-1:0]   pend_addr;

  logic                    out_free;
  logic                    step;
  logic [PIX_W-1:0]        pattern;
  logic [ADDR_WIDTH-1:0]   pix_addr;
  logic                    push;
  logic                    push_last;

  assign busy     = (state != R_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign step     = (state == R_BITS) && out_free;

  // Fresh font row on the first column, shifted remainder after that
  assign pattern  = (col == '0) ? rd_data : shreg;
  assign pix_addr = row_addr + ADDR_WIDTH'(col);

  // Next state and font reads
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = {code, row + ROW_W'(1)};
    push       = 1'b0;
    push_last  = 1'b0;
    unique case (state)
      R_IDLE: begin
        if (start) begin
          rd_en      = 1'b1;
          rd_addr    = {job.code, ROW_W'(0)};
          state_next = R_BITS;
        end
      end
      R_BITS: begin
        if (step) begin
          // A new set bit releases the held one, which is then not the last
          push = pattern[PIX_W-1] && pend_valid;
          if (col == LAST_COL) begin
            if (row == LAST_ROW) begin
              state_next = R_FLUSH;
            end else begin
              rd_en = 1'b1;
            end
          end
        end
      end
      R_FLUSH: begin
        if (out_free) begin
          push       = pend_valid;
          push_last  = 1'b1;
          state_next = R_IDLE;
        end
      end
      default: begin
        state_next = R_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= R_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == R_IDLE && start) begin
        pend_valid <= 1'b0;
      end else if (step && pattern[PIX_W-1]) begin
        pend_valid <= 1'b1;
      end else if (state == R_FLUSH && out_free) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan counters and shift register
  always_ff @(posedge clk) begin
    if (state == R_IDLE && start) begin
      code     <= job.code;
      colour   <= job.colour;
      row_addr <= job.origin;
      row      <= '0;
      col      <= '0;
    end else if (step) begin
      shreg <= pattern << 1;
      col   <= col + COL_W'(1);
      if (pattern[PIX_W-1]) begin
        pend_addr <= pix_addr;
      end
      if (col == LAST_COL) begin
        row_addr <= row_addr + ADDR_WIDTH'(line_pitch);
        row      <= row + ROW_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (push) begin
      write_addr <= pend_addr;
      write_data <= colour;
      last_write <= push_last;
    end
  end

endmodule
`default_nettype wire

>>> src/bitmap_glyph_text_blitter_top.sv
// Top level of the bitmap glyph text blitter: config registers, pen, font store and sequencing.
`timescale 1ns / 1ps
`default_nettype none
// Renders 8x8 glyphs into a byte-per-pixel frame buffer. A load transfer
// writes one font row into a 2048-byte font store; the store is not cleared
// by reset, so a glyph must be loaded before it is drawn. A draw transfer
// emits one write per set glyph bit, rows top to bottom, bit 7 leftmost, with
// last_write on the final one. Glyph rows are scanned one bit per cycle while
// the output is not stalled. On a string start the draw first waits for the
// bit-serial line-base multiply, which takes one bit of clip_top + start_y per
// cycle. A new transfer is taken while the last write still waits in the
// output register.
module bitmap_glyph_text_blitter_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bgtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bgtb_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            cmd,
  input  wire logic [bgtb_pkg::CODE_W-1:0]     char_code,
  input  wire logic [bgtb_pkg::ROW_W-1:0]      glyph_row,
  input  wire logic [bgtb_pkg::PIX_W-1:0]      row_bits,
  input  wire logic                            string_start,
  input  wire logic [bgtb_pkg::CLIP_W-1:0]     start_x,
  input  wire logic [bgtb_pkg::CLIP_W-1:0]     start_y,
  input  wire logic [bgtb_pkg::PIX_W-1:0]      colour,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [bgtb_pkg::ADDR_WIDTH-1:0] write_addr,
  output logic      [bgtb_pkg::PIX_W-1:0]      write_data,
  output logic                                 last_write
);
  import bgtb_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_LINE = 3'b010,
    T_DRAW = 3'b100
  } top_state_t;

  // Configuration registers
  logic [BASE_W-1:0]     frame_base;
  logic [PITCH_W-1:0]    line_pitch;
  logic [CLIP_W-1:0]     clip_left;
  logic [CLIP_W-1:0]     clip_top;

  // Pen and sequencing state
  top_state_t            state;
  top_state_t            state_next;
  logic [PEN_W-1:0]      pen_x;
  logic [PEN_W-1:0]      pen_x_next;
  logic [ADDR_WIDTH-1:0] pen_line_base;
  logic [ADDR_WIDTH-1:0] pen_line_base_next;

  // Latched draw transfer
  logic [CODE_W-1:0]     draw_code;
  logic [PIX_W-1:0]      draw_colour;
  logic                  draw_sstart;

  logic                  in_xfer;
  logic                  mac_start;
  logic                  mac_busy;
  logic [ADDR_WIDTH-1:0] mac_acc;
  logic                  base_ready;
  logic [ADDR_WIDTH-1:0] base_sel;
  logic                  rs_start;
  logic                  rs_busy;
  bgtb_job_t             rs_job;
  logic                  ram_we;
  logic                  ram_re;
  logic [STORE_AW-1:0]   ram_raddr;
  logic [PIX_W-1:0]      ram_rdata;

  assign in_stall = (state != T_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Line base is either freshly computed or carried over from the string
  assign base_ready    = !draw_sstart || !mac_busy;
  assign base_sel      = draw_sstart ? mac_acc : pen_line_base;
  assign rs_job.code   = draw_code[GLYPH_IDX_W-1:0];
  assign rs_job.colour = draw_colour;
  assign rs_job.origin = base_sel + ADDR_WIDTH'(pen_x);

  // Sequencing
  always_comb begin
    state_next         = state;
    pen_x_next         = pen_x;
    pen_line_base_next = pen_line_base;
    mac_start          = 1'b0;
    rs_start           = 1'b0;
    ram_we             = 1'b0;
    unique case (state)
      T_IDLE: begin
        if (in_xfer) begin
          if (cmd == CMD_LOAD) begin
            ram_we = glyph_ok(char_code);
          end else begin
            if (string_start) begin
              pen_x_next = PEN_W'(clip_left) + PEN_W'(start_x);
              mac_start  = 1'b1;
            end
            state_next = T_LINE;
          end
        end
      end
      T_LINE: begin
        if (base_ready) begin
          pen_line_base_next = base_sel;
          if (glyph_ok(draw_code)) begin
            rs_start   = 1'b1;
            state_next = T_DRAW;
          end else begin
            pen_x_next = pen_x + GLYPH_ADVANCE;
            state_next = T_IDLE;
          end
        end
      end
      T_DRAW: begin
        if (!rs_busy) begin
          pen_x_next = pen_x + GLYPH_ADVANCE;
          state_next = T_IDLE;
        end
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      pen_x         <= '0;
      pen_line_base <= '0;
      frame_base    <= '0;
      line_pitch    <= PITCH_RESET;
      clip_left     <= '0;
      clip_top      <= '0;
    end else begin
      state         <= state_next;
      pen_x         <= pen_x_next;
      pen_line_base <= pen_line_base_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_BASE: frame_base <= cfg_data[BASE_W-1:0];
          REG_LINE_PITCH: line_pitch <= cfg_data[PITCH_W-1:0];
          REG_CLIP_LEFT:  clip_left  <= cfg_data[CLIP_W-1:0];
          REG_CLIP_TOP:   clip_top   <= cfg_data[CLIP_W-1:0];
          default:        frame_base <= frame_base;
        endcase
      end
    end
  end

  // Draw transfer capture
  always_ff @(posedge clk) begin
    if (in_xfer && cmd == CMD_DRAW) begin
      draw_code   <= char_code;
      draw_colour <= colour;
      draw_sstart <= string_start;
    end
  end

  bgtb_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .pitch (line_pitch),
    .span  (SPAN_W'(clip_top) + SPAN_W'(start_y)),
    .base  (ADDR_WIDTH'(frame_base)),
    .busy  (mac_busy),
    .acc   (mac_acc)
  );

  bgtb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({char_code[GLYPH_IDX_W-1:0], glyph_row}),
    .wdata (row_bits),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bgtb_raster u_raster (
    .clk        (clk),
    .rst        (rst),
    .start      (rs_start),
    .job        (rs_job),
    .line_pitch (line_pitch),
    .busy       (rs_busy),
    .rd_en      (ram_re),
    .rd_addr    (ram_raddr),
    .rd_data    (ram_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .write_addr (write_addr),
    .write_data (write_data),
    .last_write (last_write)
  );

endmodule
`default_nettype wire
